### rtl/core/ilrf_pkg.sv
// Shared types, frame layout constants and the CRC-16 byte step for the
// logger request framer. No dependencies.
package ilrf_pkg;

    localparam int FRAME_LEN    = 36;
    localparam int IDX_W        = $clog2(FRAME_LEN);
    localparam int REQ_W        = 88;
    localparam int SERIAL_W     = 32;

    localparam logic [7:0]  SOM_BYTE     = 8'hA5;
    localparam logic [7:0]  EOM_BYTE     = 8'h15;
    localparam logic [7:0]  FRAME_KIND   = 8'h02;
    localparam logic [15:0] CTRL_CODE    = 16'h4510;
    localparam int          HEADER_EXTRA = 15;
    localparam int          RTU_LEN      = 8;
    localparam logic [15:0] FRAME_DLEN   = 16'(HEADER_EXTRA + RTU_LEN);
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    // Byte positions within the frame
    localparam logic [IDX_W-1:0] IDX_SOM      = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_LEN_LO   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LEN_HI   = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_CTRL_LO  = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CTRL_HI  = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_RID_A    = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_RID_B    = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_SER_0    = IDX_W'(7);
    localparam logic [IDX_W-1:0] IDX_SER_1    = IDX_W'(8);
    localparam logic [IDX_W-1:0] IDX_SER_2    = IDX_W'(9);
    localparam logic [IDX_W-1:0] IDX_SER_3    = IDX_W'(10);
    localparam logic [IDX_W-1:0] IDX_KIND     = IDX_W'(11);
    localparam logic [IDX_W-1:0] IDX_TS_0     = IDX_W'(22);
    localparam logic [IDX_W-1:0] IDX_TS_1     = IDX_W'(23);
    localparam logic [IDX_W-1:0] IDX_TS_2     = IDX_W'(24);
    localparam logic [IDX_W-1:0] IDX_TS_3     = IDX_W'(25);
    localparam logic [IDX_W-1:0] IDX_SLAVE    = IDX_W'(26);
    localparam logic [IDX_W-1:0] IDX_FUNC     = IDX_W'(27);
    localparam logic [IDX_W-1:0] IDX_START_HI = IDX_W'(28);
    localparam logic [IDX_W-1:0] IDX_START_LO = IDX_W'(29);
    localparam logic [IDX_W-1:0] IDX_CNT_HI   = IDX_W'(30);
    localparam logic [IDX_W-1:0] IDX_CNT_LO   = IDX_W'(31);
    localparam logic [IDX_W-1:0] IDX_CRC_LO   = IDX_W'(32);
    localparam logic [IDX_W-1:0] IDX_CRC_HI   = IDX_W'(33);
    localparam logic [IDX_W-1:0] IDX_SUM      = IDX_W'(34);
    localparam logic [IDX_W-1:0] IDX_EOM      = IDX_W'(FRAME_LEN - 1);

    typedef struct packed {
        logic [31:0] timestamp;
        logic [15:0] end_register;
        logic [15:0] start_register;
        logic [7:0]  function_code;
        logic [7:0]  slave_id;
        logic [7:0]  request_id;
    } ilrf_req_t;

    // One byte of Modbus CRC-16, reflected polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/ilrf_req_buf.sv
// Request holding register: takes one request beat off the input stream
// and keeps it until the serializer loads it. Depends on ilrf_pkg.
module ilrf_req_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // request_id, slave_id, function_code, start_register, end_register, timestamp
    input  logic [ilrf_pkg::REQ_W-1:0]    s_axis_tdata,
    output logic                          req_valid,
    output ilrf_pkg::ilrf_req_t           req,
    input  logic                          req_take
);
    import ilrf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ilrf_req_t req_reg;

    assign s_axis_tready = !valid_reg;
    assign req_valid     = valid_reg;
    assign req           = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req_take)
        begin
            valid_next = 1'b0;
        end
        if (s_axis_tvalid && !valid_reg)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && !valid_reg)
        begin
            req_reg.request_id     <= s_axis_tdata[7:0];
            req_reg.slave_id       <= s_axis_tdata[15:8];
            req_reg.function_code  <= s_axis_tdata[23:16];
            req_reg.start_register <= s_axis_tdata[39:24];
            req_reg.end_register   <= s_axis_tdata[55:40];
            req_reg.timestamp      <= s_axis_tdata[87:56];
        end
    end

endmodule

### rtl/core/ilrf_serializer.sv
// Frame serializer: walks the 36 frame bytes of one request, folds the
// CRC and checksum in as bytes go out, and drives the output register.
// Depends on ilrf_pkg.
module ilrf_serializer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  ilrf_pkg::ilrf_req_t              req,
    output logic                             req_take,
    input  logic [ilrf_pkg::SERIAL_W-1:0]    serial,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // frame_byte
    output logic [7:0]                       m_axis_tdata,
    output logic                             m_axis_tlast
);
    import ilrf_pkg::*;

    logic             busy_reg,      busy_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    ilrf_req_t        req_reg;
    logic [15:0]      count_reg;
    logic [15:0]      crc_reg,       crc_next;
    logic [7:0]       sum_reg,       sum_next;

    logic             advance;
    logic             frame_done;
    logic             load;
    logic [7:0]       cur_byte;
    logic             in_rtu;
    logic             in_sum;

    assign advance    = busy_reg && (!out_valid_reg || m_axis_tready);
    assign frame_done = advance && (idx_reg == IDX_EOM);
    assign load       = req_valid && (!busy_reg || frame_done);
    assign req_take   = load;

    assign in_rtu = (idx_reg >= IDX_SLAVE) && (idx_reg <= IDX_CNT_LO);
    assign in_sum = (idx_reg >= IDX_LEN_LO) && (idx_reg <= IDX_CRC_HI);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        case (idx_reg)
            IDX_SOM:      cur_byte = SOM_BYTE;
            IDX_LEN_LO:   cur_byte = FRAME_DLEN[7:0];
            IDX_LEN_HI:   cur_byte = FRAME_DLEN[15:8];
            IDX_CTRL_LO:  cur_byte = CTRL_CODE[7:0];
            IDX_CTRL_HI:  cur_byte = CTRL_CODE[15:8];
            IDX_RID_A:    cur_byte = req_reg.request_id;
            IDX_RID_B:    cur_byte = req_reg.request_id;
            IDX_SER_0:    cur_byte = serial[7:0];
            IDX_SER_1:    cur_byte = serial[15:8];
            IDX_SER_2:    cur_byte = serial[23:16];
            IDX_SER_3:    cur_byte = serial[31:24];
            IDX_KIND:     cur_byte = FRAME_KIND;
            IDX_TS_0:     cur_byte = req_reg.timestamp[7:0];
            IDX_TS_1:     cur_byte = req_reg.timestamp[15:8];
            IDX_TS_2:     cur_byte = req_reg.timestamp[23:16];
            IDX_TS_3:     cur_byte = req_reg.timestamp[31:24];
            IDX_SLAVE:    cur_byte = req_reg.slave_id;
            IDX_FUNC:     cur_byte = req_reg.function_code;
            IDX_START_HI: cur_byte = req_reg.start_register[15:8];
            IDX_START_LO: cur_byte = req_reg.start_register[7:0];
            IDX_CNT_HI:   cur_byte = count_reg[15:8];
            IDX_CNT_LO:   cur_byte = count_reg[7:0];
            IDX_CRC_LO:   cur_byte = crc_reg[7:0];
            IDX_CRC_HI:   cur_byte = crc_reg[15:8];
            IDX_SUM:      cur_byte = sum_reg;
            IDX_EOM:      cur_byte = EOM_BYTE;
            default:      cur_byte = 8'h00;   // zeroed sensor, delivery, power-on fields
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + IDX_W'(1);
            if (in_rtu)
            begin
                crc_next = crc_byte(crc_reg, cur_byte);
            end
            if (in_sum)
            begin
                sum_next = sum_reg + cur_byte;
            end
        end
        if (frame_done)
        begin
            busy_next = 1'b0;
        end
        // a new frame starts right after the end byte of the previous one
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = IDX_SOM;
            crc_next  = CRC_INIT;
            sum_next  = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_SOM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        sum_reg <= sum_next;
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= frame_done;
        end
        if (load)
        begin
            req_reg   <= req;
            // register count wraps modulo 2^16
            count_reg <= req.end_register - req.start_register + 16'd1;
        end
    end

endmodule

### rtl/core/inverter_logger_request_framer_top.sv
// Logger request framer top level: config register for the logger serial,
// request buffer and frame serializer. Depends on ilrf_pkg, ilrf_req_buf,
// ilrf_serializer.
//
// Usage:
//   s_axis carries one register-read request per beat (88-bit tdata).
//   m_axis returns the 36-byte logger frame, one byte per beat, with tlast
//   on the end byte. cfg writes the 32-bit logger serial; cfg_ready is
//   always high and a write takes effect on the next cycle.
// Timing:
//   From idle, a request passes the holding register, the serializer byte
//   counter and the output register before the first frame byte is valid.
//   Each frame occupies the 36-state byte counter of the serializer, so
//   one request is taken per frame; one request waits in the holding
//   register while the previous frame drains, and frames follow with no gap.
// Reset:
//   Clears the serial to zero and drops any held request or partial frame.
// Backpressure:
//   When m_axis_tready is low the current byte holds on the output and the
//   byte counter stops; s_axis_tready falls once the holding register is full.
module inverter_logger_request_framer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // request_id, slave_id, function_code, start_register, end_register, timestamp
    input  logic [ilrf_pkg::REQ_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // frame_byte
    output logic [7:0]                    m_axis_tdata,
    // last_byte
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ilrf_pkg::SERIAL_W-1:0] cfg_data
);
    import ilrf_pkg::*;

    logic [SERIAL_W-1:0] serial_reg;
    logic                req_valid;
    ilrf_req_t           req;
    logic                req_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg <= '0;
        end
        else if (cfg_valid)
        begin
            serial_reg <= cfg_data;
        end
    end

    ilrf_req_buf u_req_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take)
    );

    ilrf_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take),
        .serial        (serial_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
